>>> rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window min/max package
// Shared constants and the control bundle that the top level hands to the
// two deque chains.
// ----------------------------------------------------------------------------
package swmm_pkg;

	localparam int WINDOW_MAX_DEF   = 64;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int CFG_WIDTH        = 7;
	localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd3;

	// Per-cycle command to every cell of a chain.
	typedef struct packed {
		logic accept; // an item enters the chain
		logic purge;  // drop the front entry and move all entries one cell forward
		logic fresh;  // the entering item starts a new sequence
	} ctrl_t;

endpackage

>>> rtl/swmm_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// Holds one deque entry (value and position). It decides locally whether
// the entry survives the entering item and takes the entry of its rear
// neighbor or the new item when the deque moves forward or grows.
// ----------------------------------------------------------------------------
module swmm_cell #(
	parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF,
	parameter int WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
	parameter int POS_WIDTH    = $clog2(2 * WINDOW_MAX),
	parameter int WIN_WIDTH    = $clog2(WINDOW_MAX + 1),
	parameter bit IS_MAX       = 1'b0,
	parameter bit FIRST        = 1'b0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swmm_pkg::ctrl_t                ctrl,
	input  logic                           shift,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic        [POS_WIDTH-1:0]    cur_pos,
	input  logic        [WIN_WIDTH-1:0]    win,
	input  logic                           prev_keep,
	input  logic                           nxt_valid,
	input  logic                           nxt_keep,
	input  logic signed [SAMPLE_WIDTH-1:0] nxt_value,
	input  logic        [POS_WIDTH-1:0]    nxt_pos,
	output logic                           entry_valid,
	output logic signed [SAMPLE_WIDTH-1:0] entry_value,
	output logic        [POS_WIDTH-1:0]    entry_pos,
	output logic                           keep,
	output logic                           expired
);

	localparam logic [POS_WIDTH:0] POS_MOD = (POS_WIDTH + 1)'(2 * WINDOW_MAX);

	logic                           valid_q, valid_d;
	logic signed [SAMPLE_WIDTH-1:0] value_q, value_d;
	logic        [POS_WIDTH-1:0]    pos_q, pos_d;
	logic        [POS_WIDTH:0]      age;
	logic                           dominated;

	// Age of the entry relative to the position of the next item, modulo
	// twice the largest window.
	always_comb begin
		if (cur_pos >= pos_q) begin
			age = {1'b0, cur_pos} - {1'b0, pos_q};
		end else begin
			age = {1'b0, cur_pos} + POS_MOD - {1'b0, pos_q};
		end
	end

	assign expired = valid_q && (age >= (POS_WIDTH + 1)'(win));

	always_comb begin
		if (IS_MAX) begin
			dominated = valid_q && (value_q <= sample);
		end else begin
			dominated = valid_q && (value_q >= sample);
		end
	end

	// Only the front cell can expire while an item enters.
	assign keep = valid_q && !dominated && !ctrl.fresh && !(FIRST && expired);

	always_comb begin
		valid_d = valid_q;
		value_d = value_q;
		pos_d   = pos_q;
		if (ctrl.purge) begin
			valid_d = nxt_valid;
			value_d = nxt_value;
			pos_d   = nxt_pos;
		end else if (ctrl.accept) begin
			// When the front expires, every surviving entry moves one cell
			// forward and the new item lands right behind the last survivor.
			priority if (shift && nxt_keep) begin
				valid_d = 1'b1;
				value_d = nxt_value;
				pos_d   = nxt_pos;
			end else if (!shift && keep) begin
				valid_d = 1'b1;
			end else if (FIRST || (shift ? keep : prev_keep)) begin
				valid_d = 1'b1;
				value_d = sample;
				pos_d   = cur_pos;
			end else begin
				valid_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
		pos_q   <= pos_d;
	end

	assign entry_valid = valid_q;
	assign entry_value = value_q;
	assign entry_pos   = pos_q;

endmodule

>>> rtl/swmm_chain.sv
// ----------------------------------------------------------------------------
// Deque chain
// A row of cells that holds one monotonic deque with its front in cell 0.
// It reports the front value and asks for a purge cycle when more than one
// front entry has left the window.
// ----------------------------------------------------------------------------
module swmm_chain #(
	parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF,
	parameter int WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
	parameter int POS_WIDTH    = $clog2(2 * WINDOW_MAX),
	parameter int WIN_WIDTH    = $clog2(WINDOW_MAX + 1),
	parameter bit IS_MAX       = 1'b0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swmm_pkg::ctrl_t                ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic        [POS_WIDTH-1:0]    cur_pos,
	input  logic        [WIN_WIDTH-1:0]    win,
	output logic signed [SAMPLE_WIDTH-1:0] front_value,
	output logic                           purge_req
);

	logic [WINDOW_MAX-1:0] valid_vec;
	logic [WINDOW_MAX-1:0] keep_vec;
	logic [WINDOW_MAX-1:0] exp_vec;
	logic [WINDOW_MAX-1:0] prev_keep_vec;
	logic [WINDOW_MAX-1:0] nxt_valid_vec;
	logic [WINDOW_MAX-1:0] nxt_keep_vec;
	logic signed [SAMPLE_WIDTH-1:0] value_arr     [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] nxt_value_arr [WINDOW_MAX];
	logic        [POS_WIDTH-1:0]    pos_arr       [WINDOW_MAX];
	logic        [POS_WIDTH-1:0]    nxt_pos_arr   [WINDOW_MAX];
	logic                           shift;
	swmm_pkg::ctrl_t                cell_ctrl;

	assign shift = exp_vec[0];

	// A purge cycle moves this chain only when its own second entry expired.
	assign cell_ctrl.accept = ctrl.accept;
	assign cell_ctrl.purge  = ctrl.purge && purge_req;
	assign cell_ctrl.fresh  = ctrl.fresh;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		if (i < WINDOW_MAX - 1) begin : g_mid
			assign nxt_valid_vec[i] = valid_vec[i+1];
			assign nxt_keep_vec[i]  = keep_vec[i+1];
			assign nxt_value_arr[i] = value_arr[i+1];
			assign nxt_pos_arr[i]   = pos_arr[i+1];
		end else begin : g_last
			assign nxt_valid_vec[i] = 1'b0;
			assign nxt_keep_vec[i]  = 1'b0;
			assign nxt_value_arr[i] = '0;
			assign nxt_pos_arr[i]   = '0;
		end

		if (i > 0) begin : g_prev
			assign prev_keep_vec[i] = keep_vec[i-1];
		end else begin : g_head
			assign prev_keep_vec[i] = 1'b0;
		end

		swmm_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.WINDOW_MAX   (WINDOW_MAX),
			.POS_WIDTH    (POS_WIDTH),
			.WIN_WIDTH    (WIN_WIDTH),
			.IS_MAX       (IS_MAX),
			.FIRST        (i == 0)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (cell_ctrl),
			.shift       (shift),
			.sample      (sample),
			.cur_pos     (cur_pos),
			.win         (win),
			.prev_keep   (prev_keep_vec[i]),
			.nxt_valid   (nxt_valid_vec[i]),
			.nxt_keep    (nxt_keep_vec[i]),
			.nxt_value   (nxt_value_arr[i]),
			.nxt_pos     (nxt_pos_arr[i]),
			.entry_valid (valid_vec[i]),
			.entry_value (value_arr[i]),
			.entry_pos   (pos_arr[i]),
			.keep        (keep_vec[i]),
			.expired     (exp_vec[i])
		);
	end

	assign front_value = value_arr[0];

	// Ages fall from front to back, so an expired second entry means at
	// least two entries must leave before the next item can enter.
	if (WINDOW_MAX > 1) begin : g_purge
		assign purge_req = exp_vec[1];
	end else begin : g_no_purge
		assign purge_req = 1'b0;
	end

	// Occupied cells always form one unbroken run starting at the front.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + 1'b1) & valid_vec) == '0)
		else $error("deque chain holds a gap between occupied cells");

	if (WINDOW_MAX > 1) begin : g_order_chk
		a_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
			valid_vec[1] |-> (IS_MAX ? (value_arr[1] < value_arr[0])
			                         : (value_arr[1] > value_arr[0])))
			else $error("deque chain lost its ordering at the front");
	end

endmodule

>>> rtl/sliding_window_min_max.sv
// ----------------------------------------------------------------------------
// Sliding window minimum and maximum
// Streams signed samples and reports the smallest and largest of the last
// window_size samples of the current sequence.
//
// Input channel: sample and new_sequence, taken when in_valid is high and
// in_stall is low. new_sequence empties both deques before its sample.
// Output channel: window_min and window_max, taken when out_valid is high and
// out_stall is low. No result comes while fewer than window_size samples of
// the sequence have arrived.
// Configuration: window_size is written when cfg_valid and cfg_ready are high;
// the user must write it only while the block is idle, which the block does
// not enforce. Zero acts as 1, values above WINDOW_MAX act as WINDOW_MAX.
// Timing: a result passes through res_s1 into the output register. One item
// is accepted per cycle while in_stall is low; after window_size shrinks, the
// first item waits for each front entry beyond the first that has left the
// shorter window, since the cell chains move forward one cell per purge cycle.
// While a result waits at a stalled output, the input takes one more item
// and then stalls until that result is taken.
// Reset empties both deques and sets window_size to 3.
// ----------------------------------------------------------------------------
module sliding_window_min_max #(
	parameter int WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]     sample,
	input  logic                               new_sequence,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]     window_min,
	output logic signed [SAMPLE_WIDTH-1:0]     window_max,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [swmm_pkg::CFG_WIDTH-1:0]     window_size
);

	localparam int POS_WIDTH = $clog2(2 * WINDOW_MAX);
	localparam int WIN_WIDTH = $clog2(WINDOW_MAX + 1);
	localparam logic [POS_WIDTH-1:0] POS_LAST = POS_WIDTH'(2 * WINDOW_MAX - 1);
	localparam logic [WIN_WIDTH-1:0] WIN_TOP  = WIN_WIDTH'(WINDOW_MAX);

	logic [swmm_pkg::CFG_WIDTH-1:0] window_size_q;
	logic [WIN_WIDTH-1:0]           win_eff;
	logic [POS_WIDTH-1:0]           pos_q;
	logic [WIN_WIDTH-1:0]           seen_q, seen_next;
	logic                           res_s1;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] min_q, max_q;
	logic signed [SAMPLE_WIDTH-1:0] min_front, max_front;
	logic                           min_purge, max_purge, purge_req;
	logic                           load_out, block, accept, purge_go, produce;
	swmm_pkg::ctrl_t                ctrl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swmm_pkg::WINDOW_SIZE_RESET;
		end else if (cfg_valid) begin
			window_size_q <= window_size;
		end
	end

	always_comb begin
		if (window_size_q == '0) begin
			win_eff = WIN_WIDTH'(1);
		end else if (32'(window_size_q) > 32'(WINDOW_MAX)) begin
			win_eff = WIN_TOP;
		end else begin
			win_eff = WIN_WIDTH'(window_size_q);
		end
	end

	// The finished result moves to the output register once the output can take
	// it, before the chains change again.
	assign load_out  = res_s1 && (!out_valid_q || !out_stall);
	assign block     = res_s1 && !load_out;
	assign purge_req = min_purge || max_purge;
	assign in_stall  = purge_req || block;
	assign accept    = in_valid && !in_stall;
	assign purge_go  = purge_req && !block;

	assign ctrl.accept = accept;
	assign ctrl.purge  = purge_go;
	assign ctrl.fresh  = new_sequence;

	always_comb begin
		if (new_sequence) begin
			seen_next = WIN_WIDTH'(1);
		end else if (seen_q == WIN_TOP) begin
			seen_next = seen_q;
		end else begin
			seen_next = seen_q + 1'b1;
		end
	end

	assign produce = seen_next >= win_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			seen_q      <= '0;
			res_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pos_q  <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
				seen_q <= seen_next;
				res_s1 <= produce;
			end else if (load_out) begin
				res_s1 <= 1'b0;
			end
			out_valid_q <= load_out || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			min_q <= min_front;
			max_q <= max_front;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_min = min_q;
	assign window_max = max_q;

	swmm_chain #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.WINDOW_MAX   (WINDOW_MAX),
		.POS_WIDTH    (POS_WIDTH),
		.WIN_WIDTH    (WIN_WIDTH),
		.IS_MAX       (1'b0)
	) u_min_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.sample      (sample),
		.cur_pos     (pos_q),
		.win         (win_eff),
		.front_value (min_front),
		.purge_req   (min_purge)
	);

	swmm_chain #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.WINDOW_MAX   (WINDOW_MAX),
		.POS_WIDTH    (POS_WIDTH),
		.WIN_WIDTH    (WIN_WIDTH),
		.IS_MAX       (1'b1)
	) u_max_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.sample      (sample),
		.cur_pos     (pos_q),
		.win         (win_eff),
		.front_value (max_front),
		.purge_req   (max_purge)
	);

	a_no_accept_in_purge: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && purge_go))
		else $error("item entered the chains during a purge cycle");

	a_min_not_above_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_s1 |-> (min_front <= max_front))
		else $error("window minimum exceeds window maximum");

	a_out_from_pending: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(res_s1))
		else $error("output became valid without a finished item");

	a_pending_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_s1 && !load_out) |=> res_s1 && $stable(pos_q))
		else $error("pending result lost or chains advanced under it");

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Sliding window min/max testbench
// Streams directed and random samples through the block under several window
// sizes, predicts every windowed minimum and maximum with a pair of
// monotonic deques of its own, and compares each result as it leaves.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW          = swmm_pkg::SAMPLE_WIDTH_DEF;
	localparam int WMAX        = swmm_pkg::WINDOW_MAX_DEF;
	localparam int CW          = swmm_pkg::CFG_WIDTH;
	localparam int IDX_W       = $clog2(WMAX);
	localparam int POS_W       = $clog2(2 * WMAX);
	localparam int PHASES      = 16;
	localparam int PHASE_ITEMS = 84;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 8;

	typedef enum logic {SIDE_MIN = 1'b0, SIDE_MAX = 1'b1} side_t;
	typedef enum logic [1:0] {PAT_MIXED, PAT_RISE, PAT_FALL} pattern_t;

	typedef struct packed {
		logic signed [SW-1:0] value;
		logic                 fresh;
	} sample_item_t;

	typedef struct packed {
		logic signed [SW-1:0] lo;
		logic signed [SW-1:0] hi;
	} bounds_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [SW-1:0] sample = '0;
	logic                 new_sequence = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [SW-1:0] window_min;
	logic signed [SW-1:0] window_max;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CW-1:0]        window_size = swmm_pkg::WINDOW_SIZE_RESET;

	sample_item_t pending_items[$];
	bounds_t      expected_bounds[$];
	int           error_count = 0;
	int           quiet_cycles = 0;
	int           long_hold_requests = 0;
	int           long_hold_served = 0;

	// Predictor state: index 0 holds the rising deque, index 1 the falling one.
	logic signed [SW-1:0] dq_val [2][WMAX];
	logic [POS_W-1:0]     dq_pos [2][WMAX];
	logic [IDX_W-1:0]     dq_head [2];
	logic [IDX_W:0]       dq_cnt [2];
	logic [POS_W-1:0]     pos_cnt = '0;
	logic [IDX_W:0]       seq_len = '0;
	logic [CW-1:0]        win_reg = swmm_pkg::WINDOW_SIZE_RESET;

	logic [CW-1:0] window_plan [PHASES] = '{7'd1, 7'd0, 7'd64, 7'd2, 7'd127, 7'd5, 7'd65,
		7'd16, 7'd64, 7'd1, 7'd33, 7'd100, 7'd8, 7'd3, 7'd0, 7'd0};

	sliding_window_min_max dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.new_sequence (new_sequence),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.window_min   (window_min),
		.window_max   (window_max),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.window_size  (window_size)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic signed [SW-1:0] got,
			input logic signed [SW-1:0] want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
		error_count = error_count + 1;
	endtask

	task automatic deque_push(input side_t side, input logic signed [SW-1:0] value,
			input logic [CW-1:0] span);
		logic [IDX_W-1:0] slot;
		logic [POS_W-1:0] age;
		logic             beaten;
		// Entries at the back that the new sample makes useless go first.
		while (dq_cnt[side] > 0) begin
			slot = IDX_W'(dq_head[side] + dq_cnt[side] - 1'b1);
			beaten = (side == SIDE_MAX) ? (dq_val[side][slot] <= value)
				: (dq_val[side][slot] >= value);
			if (!beaten)
				break;
			dq_cnt[side] = dq_cnt[side] - 1'b1;
		end
		while (dq_cnt[side] > 0) begin
			age = pos_cnt - dq_pos[side][dq_head[side]];
			if (age < span)
				break;
			dq_head[side] = dq_head[side] + 1'b1;
			dq_cnt[side] = dq_cnt[side] - 1'b1;
		end
		if (dq_cnt[side] < WMAX) begin
			slot = IDX_W'(dq_head[side] + dq_cnt[side]);
			dq_val[side][slot] = value;
			dq_pos[side][slot] = pos_cnt;
			dq_cnt[side] = dq_cnt[side] + 1'b1;
		end
	endtask

	task automatic advance_window(input logic signed [SW-1:0] value, input logic fresh);
		logic [CW-1:0] span;
		bounds_t       res;
		span = (win_reg == 0) ? CW'(1) : (win_reg > WMAX) ? CW'(WMAX) : win_reg;
		if (fresh) begin
			dq_head[SIDE_MIN] = '0;
			dq_head[SIDE_MAX] = '0;
			dq_cnt[SIDE_MIN] = '0;
			dq_cnt[SIDE_MAX] = '0;
			seq_len = '0;
		end
		deque_push(SIDE_MIN, value, span);
		deque_push(SIDE_MAX, value, span);
		if (seq_len < WMAX)
			seq_len = seq_len + 1'b1;
		if (seq_len >= span) begin
			res.lo = dq_val[SIDE_MIN][dq_head[SIDE_MIN]];
			res.hi = dq_val[SIDE_MAX][dq_head[SIDE_MAX]];
			expected_bounds = {expected_bounds, res};
		end
		pos_cnt = pos_cnt + 1'b1;
	endtask

	// Sender: one item per handshake, with a random gap after each accepted item while send_idle_on is set.
	int gap_left = 0;
	bit send_idle_on = 1'b1;

	always @(posedge clk or negedge arst_n) begin : feed
		sample_item_t nxt;
		logic         drive_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			new_sequence <= 1'b0;
			gap_left = 0;
		end else begin
			drive_valid = in_valid;
			if (in_valid && !in_stall) begin
				advance_window(sample, new_sequence);
				drive_valid = 1'b0;
				gap_left = send_idle_on ? $urandom_range(0, 7) : 0;
				if ($urandom_range(0, 31) == 0)
					send_idle_on = !send_idle_on;
			end
			if (!drive_valid) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
				end else if (pending_items.size() > 0) begin
					nxt = pending_items[0];
					pending_items.delete(0);
					sample <= nxt.value;
					new_sequence <= nxt.fresh;
					drive_valid = 1'b1;
				end
			end
			in_valid <= drive_valid;
		end
	end

	// Receiver: checks each result and draws a random stall after it while recv_idle_on is set.
	int stall_left = 0;
	int hold_left = 0;
	bit recv_idle_on = 1'b1;

	always @(posedge clk or negedge arst_n) begin : drain
		bounds_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bounds.size() == 0) begin
					report_mismatch("result with no item waiting", window_min, '0);
				end else begin
					want = expected_bounds[0];
					expected_bounds.delete(0);
					if (window_min !== want.lo)
						report_mismatch("window_min", window_min, want.lo);
					if (window_max !== want.hi)
						report_mismatch("window_max", window_max, want.hi);
				end
				stall_left = recv_idle_on ? $urandom_range(0, 7) : 0;
				if ($urandom_range(0, 31) == 0)
					recv_idle_on = !recv_idle_on;
			end
			if (long_hold_served != long_hold_requests) begin
				long_hold_served = long_hold_served + 1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left = stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("sliding_window_min_max verification failed");
			$finish;
		end
	end

	task automatic queue_item(input logic signed [SW-1:0] value, input logic fresh);
		sample_item_t it;
		it.value = value;
		it.fresh = fresh;
		pending_items = {pending_items, it};
	endtask

	task automatic wait_quiet(input int tail);
		while (pending_items.size() != 0 || in_valid || expected_bounds.size() != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	task automatic load_window(input logic [CW-1:0] span);
		@(posedge clk);
		window_size <= span;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		win_reg = span;
	endtask

	function automatic logic signed [SW-1:0] pick_sample(input pattern_t pat,
			input logic signed [SW-1:0] prev);
		int roll;
		int step;
		roll = $urandom_range(0, 99);
		step = $urandom_range(0, 3);
		case (pat)
			PAT_RISE: return SW'(prev + step);
			PAT_FALL: return SW'(prev - step);
			default: begin
				if (roll < 45)
					return SW'($urandom());
				else if (roll < 70)
					return SW'($signed($urandom_range(0, 6)) - 3);
				else if (roll < 82) begin
					case ($urandom_range(0, 3))
						0: return SW'(-32768);
						1: return SW'(32767);
						2: return SW'(0);
						default: return SW'(-1);
					endcase
				end else
					return SW'(prev + $signed($urandom_range(0, 2)) - 1);
			end
		endcase
	endfunction

	initial begin
		logic signed [SW-1:0] prev;
		logic [CW-1:0]        span;
		pattern_t             pat;
		int                   split;
		prev = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset window of three: extremes, ties, both slopes and restarts.
		queue_item(-32768, 1'b1);
		queue_item(32767, 1'b0);
		queue_item(0, 1'b0);
		queue_item(-1, 1'b0);
		queue_item(1, 1'b0);
		queue_item(1, 1'b0);
		queue_item(1, 1'b0);
		queue_item(32767, 1'b0);
		queue_item(32767, 1'b0);
		queue_item(-32768, 1'b0);
		queue_item(-32768, 1'b0);
		queue_item(-32768, 1'b0);
		queue_item(5, 1'b1);
		queue_item(4, 1'b0);
		queue_item(3, 1'b0);
		queue_item(2, 1'b0);
		queue_item(21845, 1'b0);
		queue_item(-21846, 1'b0);
		queue_item(7, 1'b1);
		queue_item(7, 1'b1);
		queue_item(8, 1'b0);
		queue_item(9, 1'b0);
		wait_quiet(TAIL_CYCLES);

		for (int ph = 0; ph < PHASES; ph++) begin
			span = (ph >= 14) ? CW'($urandom_range(0, 127)) : window_plan[ph];
			load_window(span);
			@(negedge clk);
			// A full rising or falling ramp at the largest window, then a shrink to a
			// window of two or one without a restart, purges many stale fronts.
			pat = (ph == 2) ? PAT_RISE : (ph == 8) ? PAT_FALL : PAT_MIXED;
			if (ph == 3)
				long_hold_requests = long_hold_requests + 1;
			split = $urandom_range(10, PHASE_ITEMS - 10);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == split)
					wait_quiet(0);
				prev = pick_sample(pat, prev);
				if (i == 0)
					queue_item(prev, (ph == 3 || ph == 9) ? 1'b0 : 1'($urandom_range(0, 1)));
				else
					queue_item(prev, $urandom_range(0, 47) == 0);
			end
			wait_quiet(TAIL_CYCLES);
		end

		while (expected_bounds.size() != 0) begin
			report_mismatch("result never arrived", '0, expected_bounds[0].lo);
			expected_bounds.delete(0);
		end
		if (error_count == 0)
			$display("sliding_window_min_max verification clean");
		else
			$display("sliding_window_min_max verification failed");
		$finish;
	end

endmodule
